// ----- sv/tprf_pkg.sv -----
// Shared types, codes and pixel helpers for the two-plane rectangle fill.
`default_nettype none

package tprf_pkg;

    localparam int ADDR_W = 20;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_FILL  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] COLOR_BLACK = 2'd0;
    localparam logic [1:0] COLOR_RED   = 2'd1;
    localparam logic [1:0] COLOR_WHITE = 2'd2;

    localparam logic [2:0] REG_PANEL_WIDTH  = 3'd0;
    localparam logic [2:0] REG_PANEL_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BYTES_PER_ROW = 3'd2;
    localparam logic [2:0] REG_BACKGROUND   = 3'd3;
    localparam logic [2:0] REG_FOREGROUND   = 3'd4;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLIP   = 8'b0000_0010,
        S_SPAN   = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_BYTE   = 8'b0001_0000,
        S_MODIFY = 8'b0010_0000,
        S_FETCH  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] black;
    } plane_pair_t;

    function automatic logic [7:0] edge_mask(input logic [2:0] lo, input logic [2:0] hi);
        edge_mask = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
    endfunction

    // Colour code 3 paints as white.
    function automatic plane_pair_t paint(input logic [7:0] blk, input logic [7:0] red,
                                          input logic [7:0] mask, input logic [1:0] color);
        plane_pair_t p;
        case (color)
            COLOR_BLACK:
            begin
                p.black = blk & ~mask;
                p.red   = red & ~mask;
            end
            COLOR_RED:
            begin
                p.black = blk | mask;
                p.red   = red | mask;
            end
            default:
            begin
                p.black = blk | mask;
                p.red   = red & ~mask;
            end
        endcase
        paint = p;
    endfunction

endpackage

`default_nettype wire

// ----- sv/two_plane_rect_fill.sv -----
// Top level of the two-plane rectangle fill engine with its plane memories.
`default_nettype none

// Paints clipped rectangles into a black and a red 1-bit-per-pixel plane held in
// on-chip memory, and reads back one byte of each plane. A command is one transfer
// on the slave stream; it returns exactly one result transfer. Commands run one at
// a time and the slave side is not ready while a command is at work. A clear or
// fill clips the region, works out its byte span, forms the row address with a
// shift-add multiply that steps through the bits of bytes_per_row up to its highest
// set bit, then paints each row byte by byte, writing a whole byte directly. A
// rejected or empty region skips the multiply and the painting. A stalled result
// side can hold a command in its done state while an earlier result waits. The
// single port of the plane memories sets the byte rate: a partial edge byte needs
// a read and then a write. The planes are not cleared at reset and hold unknown
// data until painted.
module two_plane_rect_fill
    import tprf_pkg::*;
#(
    parameter int PLANE_BYTES = 16384
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // left_x[11:0], top_y[23:12], region_width[34:24], region_height[45:35],
    // read_address[59:46], zero fill[63:60]
    input  wire logic [63:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // black_byte[7:0], red_byte[15:8], region_rejected[16], zero fill[23:17]
    output logic [23:0]      m_axis_tdata,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    localparam int MEM_AW = $clog2(PLANE_BYTES);

    logic [10:0] panel_width_reg;
    logic [10:0] panel_height_reg;
    logic [8:0]  bytes_per_row_reg;
    logic [1:0]  background_reg;
    logic [1:0]  foreground_reg;

    state_t      state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    logic [1:0]  func_reg, func_next;
    logic [11:0] left_x_reg, left_x_next;
    logic [11:0] top_y_reg, top_y_next;
    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic [13:0] read_addr_reg, read_addr_next;

    logic        reject_reg, reject_next;
    logic [1:0]  color_reg, color_next;
    logic [10:0] ux_reg, ux_next;
    logic [10:0] uy_reg, uy_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  last_reg, last_next;
    logic [2:0]  lo_reg, lo_next;
    logic [2:0]  hi_reg, hi_next;
    logic [10:0] rows_left_reg, rows_left_next;
    logic [7:0]  col_reg, col_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [ADDR_W-1:0] mcand_reg, mcand_next;
    logic [8:0]  mplier_reg, mplier_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]  mask_reg, mask_next;

    logic        mem_we;
    logic        mem_re;
    logic [ADDR_W-1:0] mem_addr;
    plane_pair_t wr_pair;
    logic [7:0]  black_q_reg;
    logic [7:0]  red_q_reg;
    logic [7:0]  black_mem [PLANE_BYTES];
    logic [7:0]  red_mem [PLANE_BYTES];

    logic [ADDR_W-1:0] addr_now;
    logic        addr_now_ok;
    logic        addr_reg_ok;
    logic        read_ok;
    logic [7:0]  mask_now;
    logic [11:0] x_sum;
    logic [11:0] y_sum;
    logic [10:0] ux_clamp;
    logic [10:0] uy_clamp;
    logic [10:0] end_x;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign addr_now    = row_base_reg + {{(ADDR_W - 8){1'b0}}, col_reg};
    assign addr_now_ok = ({1'b0, addr_now} < (ADDR_W + 1)'(PLANE_BYTES));
    assign addr_reg_ok = ({1'b0, addr_reg} < (ADDR_W + 1)'(PLANE_BYTES));
    assign read_ok     = ({7'b0, read_addr_reg} < (ADDR_W + 1)'(PLANE_BYTES));
    assign mask_now    = edge_mask((col_reg == first_reg) ? lo_reg : 3'd0,
                                   (col_reg == last_reg) ? hi_reg : 3'd7);
    assign ux_clamp    = left_x_reg[11] ? 11'd0 : left_x_reg[10:0];
    assign uy_clamp    = top_y_reg[11] ? 11'd0 : top_y_reg[10:0];
    assign x_sum       = {1'b0, ux_clamp} + {1'b0, width_reg};
    assign y_sum       = {1'b0, uy_clamp} + {1'b0, height_reg};
    assign end_x       = ux_reg + width_reg - 11'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg   <= 11'd400;
            panel_height_reg  <= 11'd300;
            bytes_per_row_reg <= 9'd50;
            background_reg    <= COLOR_WHITE;
            foreground_reg    <= COLOR_BLACK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:   panel_width_reg   <= cfg_data;
                REG_PANEL_HEIGHT:  panel_height_reg  <= cfg_data;
                REG_BYTES_PER_ROW: bytes_per_row_reg <= cfg_data[8:0];
                REG_BACKGROUND:    background_reg    <= cfg_data[1:0];
                REG_FOREGROUND:    foreground_reg    <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        func_next      = func_reg;
        left_x_next    = left_x_reg;
        top_y_next     = top_y_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        read_addr_next = read_addr_reg;
        reject_next    = reject_reg;
        color_next     = color_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rows_left_next = rows_left_reg;
        col_next       = col_reg;
        row_base_next  = row_base_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        addr_next      = addr_reg;
        mask_next      = mask_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = addr_now;
        wr_pair        = paint(8'h00, 8'h00, mask_now, color_reg);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next      = s_axis_tuser;
                    left_x_next    = s_axis_tdata[11:0];
                    top_y_next     = s_axis_tdata[23:12];
                    width_next     = s_axis_tdata[34:24];
                    height_next    = s_axis_tdata[45:35];
                    read_addr_next = s_axis_tdata[59:46];
                    reject_next    = 1'b0;
                    if (s_axis_tuser == FUNC_CLEAR || s_axis_tuser == FUNC_FILL)
                    begin
                        state_next = S_CLIP;
                    end
                    else if (s_axis_tuser == FUNC_READ)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CLIP:
            begin
                color_next  = (func_reg == FUNC_CLEAR) ? background_reg : foreground_reg;
                reject_next = ($signed(left_x_reg) > $signed({1'b0, panel_width_reg}))
                           || ($signed(top_y_reg) > $signed({1'b0, panel_height_reg}));
                ux_next     = ux_clamp;
                uy_next     = uy_clamp;
                if (x_sum > {1'b0, panel_width_reg})
                begin
                    width_next = panel_width_reg - ux_clamp;
                end
                if (y_sum > {1'b0, panel_height_reg})
                begin
                    height_next = panel_height_reg - uy_clamp;
                end
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                first_next     = ux_reg[10:3];
                last_next      = end_x[10:3];
                lo_next        = ux_reg[2:0];
                hi_next        = end_x[2:0];
                col_next       = ux_reg[10:3];
                rows_left_next = height_reg;
                row_base_next  = '0;
                mcand_next     = {{(ADDR_W - 11){1'b0}}, uy_reg};
                mplier_next    = bytes_per_row_reg;
                if (reject_reg || width_reg == 11'd0 || height_reg == 11'd0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mplier_reg == 9'd0)
                begin
                    state_next = S_BYTE;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        row_base_next = row_base_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[ADDR_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[8:1]};
                end
            end
            S_BYTE, S_MODIFY:
            begin
                if (state_reg == S_BYTE && mask_now != 8'hFF)
                begin
                    addr_next  = addr_now;
                    mask_next  = mask_now;
                    mem_re     = addr_now_ok;
                    state_next = S_MODIFY;
                end
                else
                begin
                    if (state_reg == S_MODIFY)
                    begin
                        mem_addr = addr_reg;
                        mem_we   = addr_reg_ok;
                        wr_pair  = paint(black_q_reg, red_q_reg, mask_reg, color_reg);
                    end
                    else
                    begin
                        mem_we = addr_now_ok;
                    end
                    state_next = S_BYTE;
                    if (col_reg == last_reg)
                    begin
                        col_next       = first_reg;
                        rows_left_next = rows_left_reg - 11'd1;
                        row_base_next  = row_base_reg
                                       + {{(ADDR_W - 9){1'b0}}, bytes_per_row_reg};
                        if (rows_left_reg == 11'd1)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 8'd1;
                    end
                end
            end
            S_FETCH:
            begin
                mem_addr   = {{(ADDR_W - 14){1'b0}}, read_addr_reg};
                mem_re     = read_ok;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    if (func_reg == FUNC_READ && read_ok)
                    begin
                        out_data_next[7:0]  = black_q_reg;
                        out_data_next[15:8] = red_q_reg;
                    end
                    out_data_next[16] = reject_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        func_reg      <= func_next;
        left_x_reg    <= left_x_next;
        top_y_reg     <= top_y_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        read_addr_reg <= read_addr_next;
        reject_reg    <= reject_next;
        color_reg     <= color_next;
        ux_reg        <= ux_next;
        uy_reg        <= uy_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        rows_left_reg <= rows_left_next;
        col_reg       <= col_next;
        row_base_reg  <= row_base_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        addr_reg      <= addr_next;
        mask_reg      <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            black_mem[mem_addr[MEM_AW-1:0]] <= wr_pair.black;
            red_mem[mem_addr[MEM_AW-1:0]]   <= wr_pair.red;
        end
        if (mem_re)
        begin
            black_q_reg <= black_mem[mem_addr[MEM_AW-1:0]];
            red_q_reg   <= red_mem[mem_addr[MEM_AW-1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- tb/tprf_plane_checker.sv -----
// Checker for the two-plane rectangle fill: mirrors both plane images and compares every result.
module tprf_plane_checker
    import tprf_pkg::*;
#(
    parameter int PLANE_BYTES = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,

    output int          mismatches,
    output int          replies_owed,
    output int          replies_seen,
    output int          reads_seen,
    output int          rejects_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MIRROR_AW = $clog2(PLANE_BYTES);

    typedef struct packed {
        logic [7:0] black;
        logic [7:0] red;
        logic       rejected;
    } plane_reply_t;

    plane_reply_t reply_queue[$];

    int         panel_w;
    int         panel_h;
    int         row_stride;
    logic [1:0] clear_color;
    logic [1:0] fill_color;
    logic [7:0] black_mirror[0:PLANE_BYTES-1];
    logic [7:0] red_mirror[0:PLANE_BYTES-1];

    initial
    begin
        for (int i = 0; i < PLANE_BYTES; i++)
        begin
            black_mirror[i[MIRROR_AW-1:0]] = 8'h00;
            red_mirror[i[MIRROR_AW-1:0]]   = 8'h00;
        end
    end

    task automatic paint_mirror(input logic signed [11:0] left_col,
                                input logic signed [11:0] top_row,
                                input logic [10:0] width, input logic [10:0] height,
                                input logic [1:0] color, output logic rejected);
        int         x;
        int         y;
        int         w;
        int         h;
        int         first_byte;
        int         last_byte;
        int         lo;
        int         hi;
        int         addr;
        int         r;
        int         b;
        logic [7:0] mask;

        x = int'(left_col);
        y = int'(top_row);
        w = int'(width);
        h = int'(height);
        rejected = 1'b0;
        if (x > panel_w || y > panel_h)
        begin
            rejected = 1'b1;
            return;
        end
        // A negative start is pulled to the edge, but the size is kept as given.
        if (x < 0)
            x = 0;
        if (y < 0)
            y = 0;
        if (x + w > panel_w)
            w = panel_w - x;
        if (y + h > panel_h)
            h = panel_h - y;
        if (w == 0 || h == 0)
            return;

        first_byte = x / 8;
        last_byte  = (x + w - 1) / 8;
        for (r = 0; r < h; r++)
        begin
            for (b = first_byte; b <= last_byte; b++)
            begin
                lo   = (b == first_byte) ? (x % 8) : 0;
                hi   = (b == last_byte) ? ((x + w - 1) % 8) : 7;
                mask = 8'hFF >> lo;
                mask = mask & (8'hFF << (7 - hi));
                addr = (y + r) * row_stride + b;
                if (addr < PLANE_BYTES)
                begin
                    case (color)
                        COLOR_BLACK:
                        begin
                            black_mirror[addr[MIRROR_AW-1:0]] =
                                black_mirror[addr[MIRROR_AW-1:0]] & ~mask;
                            red_mirror[addr[MIRROR_AW-1:0]]   =
                                red_mirror[addr[MIRROR_AW-1:0]] & ~mask;
                        end
                        COLOR_RED:
                        begin
                            black_mirror[addr[MIRROR_AW-1:0]] =
                                black_mirror[addr[MIRROR_AW-1:0]] | mask;
                            red_mirror[addr[MIRROR_AW-1:0]]   =
                                red_mirror[addr[MIRROR_AW-1:0]] | mask;
                        end
                        default:
                        begin
                            black_mirror[addr[MIRROR_AW-1:0]] =
                                black_mirror[addr[MIRROR_AW-1:0]] | mask;
                            red_mirror[addr[MIRROR_AW-1:0]]   =
                                red_mirror[addr[MIRROR_AW-1:0]] & ~mask;
                        end
                    endcase
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        plane_reply_t seen;
        plane_reply_t want;
        int           addr;

        if (!rst_n)
        begin
            panel_w      = 400;
            panel_h      = 300;
            row_stride   = 50;
            clear_color  = COLOR_WHITE;
            fill_color   = COLOR_BLACK;
            reply_queue.delete();
            mismatches   = 0;
            replies_owed = 0;
            replies_seen = 0;
            reads_seen   = 0;
            rejects_seen = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                replies_seen++;
                seen.black    = m_axis_tdata[7:0];
                seen.red      = m_axis_tdata[15:8];
                seen.rejected = m_axis_tdata[16];
                if (reply_queue.size() == 0)
                begin
                    mismatches++;
                    $error("result transfer %06h arrived with no command outstanding",
                           m_axis_tdata);
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (seen.black !== want.black)
                    begin
                        mismatches++;
                        $error("black_byte: expected %02h, got %02h", want.black, seen.black);
                    end
                    if (seen.red !== want.red)
                    begin
                        mismatches++;
                        $error("red_byte: expected %02h, got %02h", want.red, seen.red);
                    end
                    if (seen.rejected !== want.rejected)
                    begin
                        mismatches++;
                        $error("region_rejected: expected %0b, got %0b",
                               want.rejected, seen.rejected);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                want = '0;
                case (s_axis_tuser)
                    FUNC_CLEAR, FUNC_FILL:
                    begin
                        paint_mirror(s_axis_tdata[11:0], s_axis_tdata[23:12],
                                     s_axis_tdata[34:24], s_axis_tdata[45:35],
                                     (s_axis_tuser == FUNC_CLEAR) ? clear_color : fill_color,
                                     want.rejected);
                        if (want.rejected)
                            rejects_seen++;
                    end
                    FUNC_READ:
                    begin
                        reads_seen++;
                        addr = int'(s_axis_tdata[59:46]);
                        if (addr < PLANE_BYTES)
                        begin
                            want.black = black_mirror[addr[MIRROR_AW-1:0]];
                            want.red   = red_mirror[addr[MIRROR_AW-1:0]];
                        end
                    end
                    default:
                    begin
                    end
                endcase
                reply_queue.push_back(want);
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PANEL_WIDTH:   panel_w     = int'(cfg_data);
                    REG_PANEL_HEIGHT:  panel_h     = int'(cfg_data);
                    REG_BYTES_PER_ROW: row_stride  = int'(cfg_data[8:0]);
                    REG_BACKGROUND:    clear_color = cfg_data[1:0];
                    REG_FOREGROUND:    fill_color  = cfg_data[1:0];
                    default:
                    begin
                    end
                endcase
            end

            replies_owed = reply_queue.size();
        end
    end

endmodule

// ----- tb/tb_two_plane_rect_fill.sv -----
// Testbench top for the two-plane rectangle fill: drives commands and settings, gives the verdict.
module tb_two_plane_rect_fill;
    timeunit 1ns;
    timeprecision 1ps;

    import tprf_pkg::*;

    localparam int         PLANE_BYTES    = 16384;
    localparam int         WATCHDOG_LIMIT = 100000;
    localparam int         HOLD_CYCLES    = 64;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam logic [1:0] COLOR_SPARE    = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;

    int mismatches;
    int replies_owed;
    int replies_seen;
    int reads_seen;
    int rejects_seen;
    int stall_cycles;
    int commands_sent;
    int settings_used;
    int recent_base;
    int cur_pw;
    int cur_ph;
    int cur_bpr;
    bit quiet;
    bit long_hold;

    two_plane_rect_fill #(
        .PLANE_BYTES(PLANE_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    tprf_plane_checker #(
        .PLANE_BYTES(PLANE_BYTES)
    ) plane_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .replies_owed(replies_owed),
        .replies_seen(replies_seen),
        .reads_seen(reads_seen),
        .rejects_seen(rejects_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL two_plane_rect_fill");
            $finish;
        end
    end

    // Result side: short random stalls, calm stretches, and one long hold on request.
    initial
    begin : result_sink
        int calm_left;

        calm_left = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!quiet && calm_left == 0 && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 29) == 0)
                    calm_left = 20;
            end
        end
    end

    task automatic send_cmd(input logic [1:0] func, input logic [11:0] left_col,
                            input logic [11:0] top_row, input logic [10:0] width,
                            input logic [10:0] height, input logic [13:0] addr);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'b0000, addr, height, width, top_row, left_col};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        commands_sent++;
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        while (replies_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[10:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_panel(input int pw, input int ph, input int bpr,
                             input logic [1:0] bg, input logic [1:0] fg);
        wait_for_replies();
        write_reg(REG_PANEL_WIDTH, pw);
        write_reg(REG_PANEL_HEIGHT, ph);
        write_reg(REG_BYTES_PER_ROW, bpr);
        write_reg(REG_BACKGROUND, int'(bg));
        write_reg(REG_FOREGROUND, int'(fg));
        cfg_valid <= 1'b0;
        cur_pw  = pw;
        cur_ph  = ph;
        cur_bpr = bpr;
        settings_used++;
    endtask

    task automatic random_command(input int cap);
        int pick;
        int x;
        int y;
        int w;
        int h;
        bit cheap;

        cheap = (cur_ph * (cur_pw / 8 + 2) <= 20000);
        pick  = $urandom_range(0, 99);
        if (pick < 28)
        begin
            if ($urandom_range(0, 1))
                send_cmd(FUNC_READ, 12'($urandom), 12'($urandom), 11'($urandom),
                         11'($urandom), 14'($urandom_range(0, PLANE_BYTES - 1)));
            else
                send_cmd(FUNC_READ, 0, 0, 0, 0, 14'(recent_base + $urandom_range(0, 3)));
        end
        else if (pick < 32)
        begin
            send_cmd(FUNC_UNUSED, 12'($urandom), 12'($urandom), 11'($urandom),
                     11'($urandom), 14'($urandom));
        end
        else
        begin
            if (pick < 40)
            begin
                x = $urandom_range(0, 4095) - 2048;
                y = $urandom_range(0, 4095) - 2048;
            end
            else
            begin
                x = ($urandom_range(0, 7) == 0) ? -$urandom_range(1, 20)
                                                : $urandom_range(0, cur_pw + 1);
                y = ($urandom_range(0, 7) == 0) ? -$urandom_range(1, 20)
                                                : $urandom_range(0, cur_ph + 1);
            end
            if (cheap && $urandom_range(0, 9) == 0)
            begin
                w = $urandom_range(0, 2047);
                h = $urandom_range(0, 2047);
            end
            else
            begin
                w = $urandom_range(0, cap);
                h = $urandom_range(0, cap);
            end
            recent_base = ((y < 0) ? 0 : y) * cur_bpr + ((x < 0) ? 0 : x) / 8;
            send_cmd(pick[0] ? FUNC_FILL : FUNC_CLEAR, 12'(x), 12'(y), 11'(w), 11'(h),
                     14'($urandom));
        end
    endtask

    initial
    begin
        int pw;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        stall_cycles  = 0;
        commands_sent = 0;
        settings_used = 0;
        recent_base   = 0;
        quiet         = 1'b0;
        long_hold     = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Paint every plane byte once so that any later read sees written data.
        set_panel(2040, 65, 255, COLOR_WHITE, COLOR_BLACK);
        send_cmd(FUNC_CLEAR, 0, 0, 2040, 65, 0);

        set_panel(400, 300, 50, COLOR_WHITE, COLOR_BLACK);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 16383);
        send_cmd(FUNC_FILL, 12'h800, 12'h800, 0, 0, 0);
        send_cmd(FUNC_FILL, 2047, 2047, 2047, 2047, 0);
        send_cmd(FUNC_CLEAR, 401, 0, 8, 8, 0);
        send_cmd(FUNC_CLEAR, 400, 10, 5, 5, 0);
        send_cmd(FUNC_CLEAR, 0, 300, 1, 1, 0);
        send_cmd(FUNC_FILL, 12'hFFB, 12'hFFB, 2047, 2047, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 14999);
        send_cmd(FUNC_CLEAR, 3, 2, 3, 2, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 100);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 150);
        send_cmd(FUNC_CLEAR, 6, 4, 12, 1, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 200);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 201);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 202);
        send_cmd(FUNC_CLEAR, 8, 5, 16, 1, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 251);
        send_cmd(FUNC_CLEAR, 390, 295, 100, 100, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 14798);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 14999);
        send_cmd(FUNC_UNUSED, 12'hFFF, 12'hFFF, 2047, 2047, 16383);
        cur_pw = 400;
        for (int i = 0; i < 30; i++)
        begin
            if (i == 10)
                long_hold = 1'b1;
            if (i == 20)
                wait_for_replies();
            random_command(40);
        end

        // Largest panel, with a stride of 256 bytes: most rows land beyond the planes and are dropped.
        set_panel(2047, 2047, 256, COLOR_RED, COLOR_SPARE);
        send_cmd(FUNC_FILL, 2040, 2040, 2047, 2047, 0);
        send_cmd(FUNC_CLEAR, 0, 0, 16, 3, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 0);
        send_cmd(FUNC_READ, 0, 0, 0, 0, 257);
        for (int i = 0; i < 15; i++)
            random_command(24);

        set_panel(1, 1, 1, COLOR_BLACK, COLOR_RED);
        for (int i = 0; i < 10; i++)
            random_command(2047);

        pw = $urandom_range(8, 200);
        set_panel(pw, $urandom_range(8, 120),
                  $urandom_range(0, 1) ? (pw + 7) / 8 : $urandom_range(1, 64),
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        for (int i = 0; i < 10; i++)
            random_command(64);

        pw = $urandom_range(8, 200);
        set_panel(pw, $urandom_range(8, 120),
                  $urandom_range(0, 1) ? (pw + 7) / 8 : $urandom_range(1, 64),
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        quiet = 1'b1;
        for (int i = 0; i < 10; i++)
            random_command(64);

        wait_for_replies();
        repeat (20) @(negedge clk);

        $display("Ran %0d commands (%0d reads, %0d rejected regions) over %0d panel settings.",
                 commands_sent, reads_seen, rejects_seen, settings_used);
        $display("Compared %0d results against the mirrored plane images.", replies_seen);
        if (mismatches == 0 && replies_owed == 0)
            $display("PASS two_plane_rect_fill");
        else
            $display("FAIL two_plane_rect_fill");
        $finish;
    end

endmodule
